[src/ptrm_pkg.sv]
// ---------------------------------------------------------------------------
// ptrm_pkg
// Shared constants, types and helpers for the pedal torque request map.
// ---------------------------------------------------------------------------
package ptrm_pkg;

  localparam int SAMPLE_W  = 10;
  localparam int LIMIT_W   = 10;
  localparam int TORQUE_W  = 15;
  localparam int PCT_W     = 7;            // percent 0..100
  localparam int NUM_W     = SAMPLE_W + PCT_W;  // 100 * sample difference
  localparam int DIV_STEPS = PCT_W;        // one quotient bit per stage
  localparam int IDX_W     = 3;
  localparam int PROD_W    = PCT_W + LIMIT_W;
  localparam int TENTH_W   = 14;

  // stream widths, padded to whole bytes
  localparam int S_TDATA_W = ((2 * SAMPLE_W + 2 + 7) / 8) * 8;
  localparam int M_TDATA_W = ((1 + TORQUE_W + LIMIT_W + 7) / 8) * 8;

  localparam int COAST_PCT = 20;
  localparam int PCT_FULL  = 100;
  localparam int BRAKE_PCT = PCT_FULL - COAST_PCT;
  localparam int TORQUE_SAT = 10000;

  // x / 100 as (x * 10486) >> 20, exact for x below 43690
  localparam int RECIP100    = 10486;
  localparam int RECIP100_SH = 20;
  localparam int DIV100_IN_W = 14;
  // x / 10 as (x * 104858) >> 20, exact for x below 2**18
  localparam int RECIP10    = 104858;
  localparam int RECIP10_SH = 20;
  localparam int BIG_W      = 2 * NUM_W;

  // configuration register indexes
  localparam logic [IDX_W-1:0] REG_APPS_REGEN_START  = 3'd0;
  localparam logic [IDX_W-1:0] REG_THROTTLE_LO       = 3'd1;
  localparam logic [IDX_W-1:0] REG_THROTTLE_HI       = 3'd2;
  localparam logic [IDX_W-1:0] REG_PEDAL_MAX         = 3'd3;
  localparam logic [IDX_W-1:0] REG_BRAKE_REGEN_START = 3'd4;
  localparam logic [IDX_W-1:0] REG_BRAKE_REGEN_END   = 3'd5;
  localparam logic [IDX_W-1:0] REG_DRIVE_LIM         = 3'd6;
  localparam logic [IDX_W-1:0] REG_REGEN_LIM         = 3'd7;

  // accelerator zones
  typedef logic [2:0] zone_t;
  localparam zone_t ZONE_COAST = 3'd0;
  localparam zone_t ZONE_BLEND = 3'd1;
  localparam zone_t ZONE_RAMP  = 3'd2;
  localparam zone_t ZONE_FULL  = 3'd3;
  localparam zone_t ZONE_ZERO  = 3'd4;

  typedef struct packed {
    logic  ok;
    logic  regen;
    logic  bempty;
    zone_t zone;
  } meta_t;

  function automatic logic [PCT_W-1:0] div100(input logic [DIV100_IN_W-1:0] x);
    logic [DIV100_IN_W+RECIP100_SH-1:0] p;
    p = (DIV100_IN_W+RECIP100_SH)'(x) * (DIV100_IN_W+RECIP100_SH)'(RECIP100);
    return p[RECIP100_SH +: PCT_W];
  endfunction

endpackage

[src/ptrm_div.sv]
// ---------------------------------------------------------------------------
// ptrm_div
// Pipelined restoring divider, one quotient bit per stage. The dividend
// must stay below 2**DIV_STEPS times the divisor.
// ---------------------------------------------------------------------------
module ptrm_div
  import ptrm_pkg::*;
(
  input  logic                 clk,
  input  logic [DIV_STEPS-1:0] adv,
  input  logic [NUM_W-1:0]     num,
  input  logic [SAMPLE_W-1:0]  den,
  output logic [PCT_W-1:0]     quo
);

  logic [NUM_W-1:0]    rem [DIV_STEPS];
  logic [SAMPLE_W-1:0] dsr [DIV_STEPS];
  logic [PCT_W-1:0]    qt  [DIV_STEPS];

  for (genvar k = 0; k < DIV_STEPS; k++) begin : g_step
    localparam int J = DIV_STEPS - 1 - k;
    logic [NUM_W-1:0]    r_in;
    logic [SAMPLE_W-1:0] d_in;
    logic [PCT_W-1:0]    q_in;
    logic [PCT_W-1:0]    q_out;
    logic [NUM_W:0]      sh;
    logic                ge;

    if (k == 0) begin : g_first
      assign r_in = num;
      assign d_in = den;
      assign q_in = '0;
    end else begin : g_rest
      assign r_in = rem[k-1];
      assign d_in = dsr[k-1];
      assign q_in = qt[k-1];
    end

    assign sh = (NUM_W+1)'(d_in) << J;
    assign ge = {1'b0, r_in} >= sh;

    always_comb begin
      q_out    = q_in;
      q_out[J] = ge;
    end

    always_ff @(posedge clk) begin
      if (adv[k]) begin
        rem[k] <= ge ? r_in - sh[NUM_W-1:0] : r_in;
        dsr[k] <= d_in;
        qt[k]  <= q_out;
      end
    end
  end

  assign quo = qt[DIV_STEPS-1];

endmodule

[src/pedal_torque_request_map_top.sv]
// ---------------------------------------------------------------------------
// pedal_torque_request_map_top
// Maps accelerator and brake samples to a signed torque request in tenths.
//
//   channel  dir  beat contents (low bit first)
//   s_*      in   apps_position[9:0], brake_position[9:0], regen_allowed,
//                 torque_ok
//   m_*      out  drive_enable, torque_request_x10[14:0], limit_sent[9:0]
//   cfg_*    in   register write: cfg_index selects, cfg_data is the value
//
// Twelve register stages: zone decode, seven divider steps (one quotient
// bit each), percent blend, limit multiply, divide-by-ten multiply, output.
// One beat per cycle while m_tready is held high.
// A stalled output fills empty stages first; s_tready drops only when
// every stage holds a beat. Reset empties the pipe and loads the register
// defaults.
// ---------------------------------------------------------------------------
module pedal_torque_request_map_top
  import ptrm_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [S_TDATA_W-1:0] s_tdata,   // apps_position, brake_position, regen_allowed, torque_ok
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [M_TDATA_W-1:0] m_tdata,   // drive_enable, torque_request_x10, limit_sent
  input  logic                 cfg_we,
  input  logic [IDX_W-1:0]     cfg_index,
  input  logic [LIMIT_W-1:0]   cfg_data
);

  localparam int NST  = DIV_STEPS + 5;
  localparam int S_P8 = DIV_STEPS + 1;
  localparam int S_OUT = NST - 1;

  // configuration registers
  logic [SAMPLE_W-1:0] apps_regen_start, throttle_lo, throttle_hi;
  logic [SAMPLE_W-1:0] pedal_max, brake_regen_start, brake_regen_end;
  logic [LIMIT_W-1:0]  drive_lim, regen_lim;

  always_ff @(posedge clk) begin
    if (rst) begin
      apps_regen_start    <= '0;
      throttle_lo         <= '0;
      throttle_hi         <= SAMPLE_W'(1023);
      pedal_max           <= SAMPLE_W'(1023);
      brake_regen_start   <= '0;
      brake_regen_end     <= SAMPLE_W'(1023);
      drive_lim           <= LIMIT_W'(23);
      regen_lim           <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_APPS_REGEN_START:  apps_regen_start  <= cfg_data[SAMPLE_W-1:0];
        REG_THROTTLE_LO:       throttle_lo       <= cfg_data[SAMPLE_W-1:0];
        REG_THROTTLE_HI:       throttle_hi       <= cfg_data[SAMPLE_W-1:0];
        REG_PEDAL_MAX:         pedal_max         <= cfg_data[SAMPLE_W-1:0];
        REG_BRAKE_REGEN_START: brake_regen_start <= cfg_data[SAMPLE_W-1:0];
        REG_BRAKE_REGEN_END:   brake_regen_end   <= cfg_data[SAMPLE_W-1:0];
        REG_DRIVE_LIM:         drive_lim         <= cfg_data;
        REG_REGEN_LIM:         regen_lim         <= cfg_data;
        default: ;
      endcase
    end
  end

  // valid bits and per-stage advance (bubbles collapse on a stall)
  logic [NST-1:0] vld;
  logic [NST-1:0] adv;

  always_comb begin
    adv[NST-1] = ~vld[NST-1] | m_tready;
    for (int k = NST - 2; k >= 0; k--) begin
      adv[k] = ~vld[k] | adv[k+1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (adv[0]) vld[0] <= s_tvalid;
      for (int k = 1; k < NST; k++) begin
        if (adv[k]) vld[k] <= vld[k-1];
      end
    end
  end

  assign s_tready = adv[0];

  // stage 0: zone decode and divider operands
  logic [SAMPLE_W-1:0] in_a, in_b, bv;
  meta_t               in_meta;
  logic [SAMPLE_W-1:0] in_an, in_ad;

  assign in_a = s_tdata[SAMPLE_W-1:0];
  assign in_b = s_tdata[2*SAMPLE_W-1:SAMPLE_W];

  always_comb begin
    in_meta.ok     = s_tdata[2*SAMPLE_W+1];
    in_meta.regen  = s_tdata[2*SAMPLE_W];
    in_meta.bempty = brake_regen_end <= brake_regen_start;
    in_an = '0;
    in_ad = '0;
    if (in_a < apps_regen_start) begin
      in_meta.zone = ZONE_COAST;
    end else if (in_a < throttle_lo) begin
      in_meta.zone = ZONE_BLEND;
      in_an = throttle_lo - in_a;
      in_ad = throttle_lo - apps_regen_start;
    end else if (in_a < throttle_hi) begin
      in_meta.zone = ZONE_RAMP;
      in_an = in_a - throttle_lo;
      in_ad = throttle_hi - throttle_lo;
    end else if (in_a < pedal_max) begin
      in_meta.zone = ZONE_FULL;
    end else begin
      in_meta.zone = ZONE_ZERO;
    end
    bv = in_b;
    if (bv < brake_regen_start) bv = brake_regen_start;
    if (bv > brake_regen_end)   bv = brake_regen_end;
  end

  meta_t               mt [DIV_STEPS+1];
  logic [SAMPLE_W-1:0] a_n, a_d, b_n, b_d;

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      mt[0] <= in_meta;
      a_n   <= in_an;
      a_d   <= in_ad;
      b_n   <= bv - brake_regen_start;
      b_d   <= brake_regen_end - brake_regen_start;
    end
    for (int k = 1; k <= DIV_STEPS; k++) begin
      if (adv[k]) mt[k] <= mt[k-1];
    end
  end

  // stages 1..DIV_STEPS: both shares divided side by side
  logic [PCT_W-1:0] quo_a, quo_b;

  ptrm_div u_div_apps (
    .clk (clk),
    .adv (adv[DIV_STEPS:1]),
    .num (NUM_W'(a_n) * NUM_W'(PCT_FULL)),
    .den (a_d),
    .quo (quo_a)
  );

  ptrm_div u_div_brake (
    .clk (clk),
    .adv (adv[DIV_STEPS:1]),
    .num (NUM_W'(b_n) * NUM_W'(PCT_FULL)),
    .den (b_d),
    .quo (quo_b)
  );

  // percent blend
  meta_t              md;
  logic [PCT_W-1:0]   bs, brake_part, pct_next;
  logic [LIMIT_W-1:0] lim_next;
  logic               neg_next;

  assign md = mt[DIV_STEPS];

  always_comb begin
    bs         = md.bempty ? '0 : quo_b;
    brake_part = div100(DIV100_IN_W'(bs) * DIV100_IN_W'(BRAKE_PCT));
    pct_next   = '0;
    lim_next   = drive_lim;
    neg_next   = 1'b0;
    case (md.zone)
      ZONE_COAST: begin
        neg_next = 1'b1;
        lim_next = regen_lim;
        if (md.regen) pct_next = PCT_W'(COAST_PCT) + brake_part;
      end
      ZONE_BLEND: begin
        neg_next = 1'b1;
        lim_next = regen_lim;
        if (md.regen) begin
          pct_next = div100(DIV100_IN_W'(quo_a) * DIV100_IN_W'(COAST_PCT)) + brake_part;
        end
      end
      ZONE_RAMP: pct_next = quo_a;
      ZONE_FULL: pct_next = PCT_W'(PCT_FULL);
      default:   pct_next = '0;
    endcase
    if (!md.ok) pct_next = '0;
  end

  logic [PCT_W-1:0]   p8_pct;
  logic [LIMIT_W-1:0] p8_lim;
  logic               p8_neg, p8_ok;
  logic [PROD_W-1:0]  p9_prod;
  logic               p9_neg, p9_ok;
  logic [BIG_W-1:0]   p10_big;
  logic               p10_neg, p10_ok;

  always_ff @(posedge clk) begin
    if (adv[S_P8]) begin
      p8_pct <= pct_next;
      p8_lim <= lim_next;
      p8_neg <= neg_next;
      p8_ok  <= md.ok;
    end
    if (adv[S_P8+1]) begin
      p9_prod <= PROD_W'(p8_pct) * PROD_W'(p8_lim);
      p9_neg  <= p8_neg;
      p9_ok   <= p8_ok;
    end
    if (adv[S_P8+2]) begin
      p10_big <= BIG_W'(p9_prod) * BIG_W'(RECIP10);
      p10_neg <= p9_neg;
      p10_ok  <= p9_ok;
    end
  end

  // output stage: saturate and apply sign
  logic [TENTH_W-1:0]     tenths, sat;
  logic [TORQUE_W-1:0]    torque_next;
  logic                   out_ok;
  logic signed [TORQUE_W-1:0] out_torque;
  logic [LIMIT_W-1:0]     out_limit;

  always_comb begin
    tenths = p10_big[RECIP10_SH +: TENTH_W];
    sat    = (tenths > TENTH_W'(TORQUE_SAT)) ? TENTH_W'(TORQUE_SAT) : tenths;
    torque_next = p10_neg ? -TORQUE_W'(sat) : TORQUE_W'(sat);
  end

  always_ff @(posedge clk) begin
    if (adv[S_OUT]) begin
      out_ok     <= p10_ok;
      out_torque <= torque_next;
      out_limit  <= p10_ok ? drive_lim : '0;
    end
  end

  assign m_tvalid = vld[S_OUT];
  assign m_tdata  = M_TDATA_W'({out_limit, out_torque, out_ok});

  // a blocked input means the whole pipe is full
  a_full_when_blocked: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> &vld)
    else $error("input blocked with an empty stage");

  // percent never exceeds full scale
  a_pct_range: assert property (@(posedge clk) disable iff (rst)
    vld[S_P8] |-> p8_pct <= PCT_W'(PCT_FULL))
    else $error("percent out of range");

  // disabled drive carries no torque and no limit
  a_disabled_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !out_ok |-> out_torque == '0 && out_limit == '0)
    else $error("torque or limit nonzero with drive disabled");

  // request stays inside saturation bounds
  a_torque_sat: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> out_torque <= TORQUE_W'(TORQUE_SAT) && out_torque >= -TORQUE_W'(TORQUE_SAT))
    else $error("torque request beyond saturation");

endmodule

[sim/torque_map_checker.sv]
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// torque_map_checker
// Watches the sample, command and register-write channels of the pedal
// torque request map, predicts each torque command from its own copy of
// the registers and compares it with the beats that leave the block.
// ---------------------------------------------------------------------------
module torque_map_checker
  import ptrm_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  input  logic                 s_tready,
  input  logic [S_TDATA_W-1:0] s_tdata,   // apps_position, brake_position, regen_allowed, torque_ok
  input  logic                 m_tvalid,
  input  logic                 m_tready,
  input  logic [M_TDATA_W-1:0] m_tdata,   // drive_enable, torque_request_x10, limit_sent
  input  logic                 cfg_we,
  input  logic [IDX_W-1:0]     cfg_index,
  input  logic [LIMIT_W-1:0]   cfg_data,
  output int                   fail_count,
  output int                   pending
);

  typedef struct packed {
    logic                       drive_en;
    logic signed [TORQUE_W-1:0] torque;
    logic [LIMIT_W-1:0]         limit;
  } torque_cmd_t;

  torque_cmd_t expected_cmds[$];

  // shadow copy of the map registers
  int apps_regen_start, apps_thr_start, apps_thr_end, pedal_max;
  int brake_lo, brake_hi, drive_limit, regen_lim;

  initial fail_count = 0;
  initial pending = 0;

  function automatic int brake_pct(input int brake);
    int v;
    if (brake_hi <= brake_lo) return 0;
    v = brake;
    if (v < brake_lo) v = brake_lo;
    if (v > brake_hi) v = brake_hi;
    return (PCT_FULL * (v - brake_lo)) / (brake_hi - brake_lo);
  endfunction

  function automatic torque_cmd_t predict_cmd(input int apps, input int brake,
                                              input logic regen, input logic ok);
    torque_cmd_t cmd;
    int pct;
    int throttle_pct;
    int t;
    cmd = '0;
    if (!ok) return cmd;
    t = 0;
    if (apps < apps_regen_start) begin
      if (regen) begin
        pct = COAST_PCT + (brake_pct(brake) * BRAKE_PCT) / PCT_FULL;
        t = -((pct * regen_lim) / 10);
      end
    end else if (apps < apps_thr_start) begin
      if (regen) begin
        throttle_pct = (PCT_FULL * (apps_thr_start - apps)) /
                       (apps_thr_start - apps_regen_start);
        pct = (throttle_pct * COAST_PCT) / PCT_FULL +
              (brake_pct(brake) * BRAKE_PCT) / PCT_FULL;
        t = -((pct * regen_lim) / 10);
      end
    end else if (apps < apps_thr_end) begin
      pct = (PCT_FULL * (apps - apps_thr_start)) / (apps_thr_end - apps_thr_start);
      t = (pct * drive_limit) / 10;
    end else if (apps < pedal_max) begin
      t = drive_limit * 10;
    end
    if (t > TORQUE_SAT) t = TORQUE_SAT;
    if (t < -TORQUE_SAT) t = -TORQUE_SAT;
    cmd.drive_en = 1'b1;
    cmd.torque   = TORQUE_W'(t);
    cmd.limit    = LIMIT_W'(drive_limit);
    return cmd;
  endfunction

  always @(posedge clk) begin : watch
    torque_cmd_t got;
    torque_cmd_t want;
    if (rst) begin
      apps_regen_start = 0;
      apps_thr_start   = 0;
      apps_thr_end     = 1023;
      pedal_max        = 1023;
      brake_lo         = 0;
      brake_hi         = 1023;
      drive_limit      = 23;
      regen_lim        = 0;
      expected_cmds.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_APPS_REGEN_START:  apps_regen_start = int'(cfg_data);
          REG_THROTTLE_LO:       apps_thr_start   = int'(cfg_data);
          REG_THROTTLE_HI:       apps_thr_end     = int'(cfg_data);
          REG_PEDAL_MAX:         pedal_max        = int'(cfg_data);
          REG_BRAKE_REGEN_START: brake_lo         = int'(cfg_data);
          REG_BRAKE_REGEN_END:   brake_hi         = int'(cfg_data);
          REG_DRIVE_LIM:         drive_limit      = int'(cfg_data);
          REG_REGEN_LIM:         regen_lim        = int'(cfg_data);
          default: ;
        endcase
      end
      if (s_tvalid && s_tready)
        expected_cmds.push_back(predict_cmd(int'(s_tdata[SAMPLE_W-1:0]),
                                            int'(s_tdata[2*SAMPLE_W-1:SAMPLE_W]),
                                            s_tdata[2*SAMPLE_W], s_tdata[2*SAMPLE_W+1]));
      if (m_tvalid && m_tready) begin
        got.drive_en = m_tdata[0];
        got.torque   = m_tdata[TORQUE_W:1];
        got.limit    = m_tdata[TORQUE_W+LIMIT_W:TORQUE_W+1];
        if (expected_cmds.size() == 0) begin
          $error("command beat with nothing outstanding: %h", m_tdata);
          fail_count++;
        end else begin
          want = expected_cmds.pop_front();
          if (got.drive_en !== want.drive_en) begin
            $error("drive_enable: expected %0d, got %0d", want.drive_en, got.drive_en);
            fail_count++;
          end
          if (got.torque !== want.torque) begin
            $error("torque_request_x10: expected %0d, got %0d",
                   want.torque, got.torque);
            fail_count++;
          end
          if (got.limit !== want.limit) begin
            $error("limit_sent: expected %0d, got %0d", want.limit, got.limit);
            fail_count++;
          end
        end
      end
    end
    pending <= expected_cmds.size();
  end

endmodule

[sim/tb.sv]
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb
// Stimulus for the pedal torque request map: a directed pass over every
// accelerator zone, regen gating, empty and inverted ranges and saturated
// limits, then random register settings with pedal samples biased toward
// the zone edges. Sender bursts and receiver stalls are random; the
// checker instance does all the comparing.
// ---------------------------------------------------------------------------
module tb
  import ptrm_pkg::*;
();

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 20;
  localparam int RAND_PHASES    = 8;
  localparam int PHASE_SAMPLES  = 80;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  logic [S_TDATA_W-1:0] s_tdata = '0;   // apps_position, brake_position, regen_allowed, torque_ok
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  logic [M_TDATA_W-1:0] m_tdata;        // drive_enable, torque_request_x10, limit_sent
  logic                 cfg_we = 1'b0;
  logic [IDX_W-1:0]     cfg_index = '0;
  logic [LIMIT_W-1:0]   cfg_data = '0;

  int fail_count;
  int pending;
  int reg_val[8];
  int burst_left = 0;
  int idle_cycles = 0;
  int rx_cycle = 0;
  int rx_mode = 0;

  pedal_torque_request_map_top dut (
    .clk, .rst,
    .s_tvalid, .s_tready, .s_tdata,
    .m_tvalid, .m_tready, .m_tdata,
    .cfg_we, .cfg_index, .cfg_data
  );

  torque_map_checker chk (
    .clk, .rst,
    .s_tvalid, .s_tready, .s_tdata,
    .m_tvalid, .m_tready, .m_tdata,
    .cfg_we, .cfg_index, .cfg_data,
    .fail_count, .pending
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // receiver: stall pattern switches between random modes
  always @(posedge clk) begin
    rx_cycle <= rx_cycle + 1;
    if (rx_cycle % 64 == 0) rx_mode <= $urandom_range(0, 3);
    case (rx_mode)
      0:       m_tready <= 1'b1;
      1:       m_tready <= 1'($urandom_range(0, 1));
      2:       m_tready <= ($urandom_range(0, 7) == 0);
      default: m_tready <= (rx_cycle % 32 == 0);
    endcase
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  // only called with the block idle
  task automatic set_regs(input int rs, input int ts, input int te, input int am,
                          input int bs, input int be, input int tl, input int rl);
    reg_val[REG_APPS_REGEN_START]  = rs;
    reg_val[REG_THROTTLE_LO]       = ts;
    reg_val[REG_THROTTLE_HI]       = te;
    reg_val[REG_PEDAL_MAX]         = am;
    reg_val[REG_BRAKE_REGEN_START] = bs;
    reg_val[REG_BRAKE_REGEN_END]   = be;
    reg_val[REG_DRIVE_LIM]         = tl;
    reg_val[REG_REGEN_LIM]         = rl;
    for (int i = 0; i < 8; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= IDX_W'(i);
      cfg_data  <= LIMIT_W'(reg_val[i]);
      @(posedge clk);
    end
    cfg_we <= 1'b0;
  endtask

  task automatic send_sample(input int apps, input int brake, input logic regen,
                             input logic ok);
    int gap;
    s_tdata  <= S_TDATA_W'({ok, regen, SAMPLE_W'(brake), SAMPLE_W'(apps)});
    s_tvalid <= 1'b1;
    do @(posedge clk); while (!s_tready);
    burst_left--;
    if (burst_left <= 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  // hold off until every command is out, then let the pipe settle
  task automatic wait_idle();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic int near_edge(input int edge_val);
    int v;
    v = edge_val + $urandom_range(0, 4) - 2;
    if (v < 0) v = 0;
    if (v > 1023) v = 1023;
    return v;
  endfunction

  function automatic int rand_sample_reg();
    case ($urandom_range(0, 5))
      0:       return 0;
      1:       return 1023;
      default: return $urandom_range(0, 1023);
    endcase
  endfunction

  function automatic int rand_limit();
    case ($urandom_range(0, 7))
      0:       return 0;
      1:       return 1023;
      2:       return 1000;
      default: return $urandom_range(1, 1000);
    endcase
  endfunction

  initial begin
    int rs, ts, te, am, bs, be;
    int apps, brake;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    burst_left = $urandom_range(1, 40);
    @(posedge clk);

    // ordered zones, every region at least once
    set_regs(300, 500, 900, 1000, 100, 800, 230, 150);
    send_sample(0, 0, 1'b1, 1'b1);
    send_sample(299, 1023, 1'b1, 1'b1);
    send_sample(150, 450, 1'b1, 1'b1);
    send_sample(100, 500, 1'b0, 1'b1);
    send_sample(300, 50, 1'b1, 1'b1);
    send_sample(499, 800, 1'b1, 1'b1);
    send_sample(400, 900, 1'b0, 1'b1);
    send_sample(500, 0, 1'b1, 1'b1);
    send_sample(899, 300, 1'b0, 1'b1);
    send_sample(900, 0, 1'b1, 1'b1);
    send_sample(999, 0, 1'b0, 1'b1);
    send_sample(1000, 0, 1'b1, 1'b1);
    send_sample(1023, 1023, 1'b1, 1'b1);
    send_sample(700, 700, 1'b1, 1'b0);
    wait_idle();

    // oversized limits saturate both ways
    set_regs(400, 600, 601, 1023, 0, 1023, 1023, 1023);
    send_sample(0, 1023, 1'b1, 1'b1);
    send_sample(600, 512, 1'b1, 1'b1);
    send_sample(601, 0, 1'b1, 1'b1);
    send_sample(1023, 0, 1'b1, 1'b1);
    wait_idle();

    // thresholds out of order, inverted brake range
    set_regs(700, 200, 100, 50, 900, 300, 0, 1000);
    send_sample(0, 1023, 1'b1, 1'b1);
    send_sample(699, 5, 1'b1, 1'b1);
    send_sample(700, 500, 1'b1, 1'b1);
    send_sample(1023, 0, 1'b1, 1'b0);
    wait_idle();

    set_regs(0, 0, 0, 0, 0, 0, 0, 0);
    send_sample(0, 0, 1'b1, 1'b1);
    send_sample(1023, 1023, 1'b1, 1'b1);
    wait_idle();

    for (int p = 0; p < RAND_PHASES; p++) begin
      if ($urandom_range(0, 9) < 7) begin
        rs = $urandom_range(0, 300);
        ts = rs + $urandom_range(0, 300);
        te = ts + $urandom_range(0, 300);
        am = te + $urandom_range(0, 123);
        bs = $urandom_range(0, 500);
        be = bs + $urandom_range(0, 523);
      end else begin
        rs = rand_sample_reg();
        ts = rand_sample_reg();
        te = rand_sample_reg();
        am = rand_sample_reg();
        bs = rand_sample_reg();
        be = rand_sample_reg();
      end
      set_regs(rs, ts, te, am, bs, be, rand_limit(), rand_limit());
      for (int n = 0; n < PHASE_SAMPLES; n++) begin
        if ($urandom_range(0, 1) == 0)
          apps = near_edge(reg_val[$urandom_range(0, 3)]);
        else
          apps = $urandom_range(0, 1023);
        if ($urandom_range(0, 1) == 0)
          brake = near_edge(reg_val[REG_BRAKE_REGEN_START + $urandom_range(0, 1)]);
        else
          brake = $urandom_range(0, 1023);
        send_sample(apps, brake, $urandom_range(0, 3) != 0, $urandom_range(0, 7) != 0);
      end
      wait_idle();
    end

    if (fail_count == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule
